[src/rsc_pkg.sv]
package rsc_pkg;

   localparam int DATA_W      = 32;
   localparam int MAX_RESULTS = 16;

   // command codes
   localparam logic [2:0] CMD_PUSH  = 3'd0;
   localparam logic [2:0] CMD_APPLY = 3'd1;
   localparam logic [2:0] CMD_PEEK  = 3'd2;
   localparam logic [2:0] CMD_DUMP  = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;

   // operator codes
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_FEW   = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_DIV0  = 3'd4;

   // stack read address selection
   localparam logic [1:0] RD_TOP    = 2'd0;
   localparam logic [1:0] RD_SECOND = 2'd1;
   localparam logic [1:0] RD_NEXT   = 2'd2;

   // response value source
   localparam logic [1:0] VAL_ZERO   = 2'd0;
   localparam logic [1:0] VAL_RESULT = 2'd1;
   localparam logic [1:0] VAL_RDATA  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       push;
      logic       pop_wb;
      logic       clear;
      logic       dump_start;
      logic       dump_step;
      logic       cap_rhs;
      logic       cap_lhs;
      logic       calc;
      logic       div_start;
      logic       div_capture;
      logic       emit;
      logic [1:0] emit_val;
      logic [2:0] emit_status;
      logic       emit_last;
   } rsc_ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic [2:0] cmd;
      logic [1:0] operator_sel;
      logic       empty;
      logic       full;
      logic       few;
      logic       rhs_zero;
      logic       div_done;
      logic       out_free;
      logic       dump_last;
   } rsc_sts_type;

endpackage

[src/rpn_stack_calculator.sv]
// reverse-polish integer calculator on a stack of STACK_DEPTH signed 32-bit entries
// request channel: req_cmd, req_number, req_operator; a transaction moves on a
// rising edge with req_valid high and req_stall low; one command at a time
// response channel: rsp_value, rsp_status, rsp_has_value, rsp_last, moved
// when rsp_valid is high and rsp_stall is low; rsp_last marks the final response
// of a command; unused command codes give no response
// sequencing from request to response:
//   push, clear, empty and too-few-operand cases: emitted from the decode state
//   peek: top entry read, then emitted; add, subtract, multiply: top and second
//   read, captured, calculated, written back; divide by zero flagged after capture
//   divide: same reads and capture, one quotient bit per cycle (32 steps), write back
//   dump: entries top first, one per cycle while the output is not held by rsp_stall
// a new request is taken once the previous command has handed its last
// response to the output register; that register holds while rsp_stall is
// high and the sequencer waits on it, so nothing is lost while the receiver stalls
// reset (synchronous, active high) empties the stack and drops any pending
// response; stack storage itself is not cleared
module rpn_stack_calculator
   import rsc_pkg::*;
#(
   parameter int STACK_DEPTH = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic        [2:0]        req_cmd,
   input  logic signed [DATA_W-1:0] req_number,
   input  logic        [1:0]        req_operator,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic        [2:0]        rsp_status,
   output logic                     rsp_has_value,
   output logic                     rsp_last
);

   rsc_ctl_type ctl;
   rsc_sts_type sts;

   rsc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   rsc_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sts           (sts),
      .req_cmd       (req_cmd),
      .req_number    (req_number),
      .req_operator  (req_operator),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .rsp_has_value (rsp_has_value),
      .rsp_last      (rsp_last)
   );

endmodule

[src/rsc_divider.sv]
module rsc_divider
   import rsc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W-1:0] dividend,
   input  logic signed [DATA_W-1:0] divisor,
   output logic                     done,
   output logic        [DATA_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   trial;

   // one restoring step per cycle on magnitudes
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = {CNT_W{1'b1}};
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
         dvs_in  = divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // sign fix-up of the magnitude quotient
   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

[src/rsc_datapath.sv]
module rsc_datapath
   import rsc_pkg::*;
#(
   parameter int STACK_DEPTH = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  rsc_ctl_type              ctl,
   output rsc_sts_type              sts,
   input  logic        [2:0]        req_cmd,
   input  logic signed [DATA_W-1:0] req_number,
   input  logic        [1:0]        req_operator,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic        [2:0]        rsp_status,
   output logic                     rsp_has_value,
   output logic                     rsp_last
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [DATA_W-1:0] mem [STACK_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic [2:0]        cmd_ff;
   logic [DATA_W-1:0] number_ff;
   logic [1:0]        operator_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     remain_ff, remain_in;
   logic [DATA_W-1:0] rhs_ff, lhs_ff;
   logic [DATA_W-1:0] result_ff, result_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff;
   logic [2:0]        rsp_status_ff;
   logic              rsp_has_value_ff;
   logic              rsp_last_ff;

   logic [IW-1:0]     top_idx, second_idx, rd_addr, wr_addr;
   logic              wr_en;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] alu_out;
   logic [DATA_W-1:0] emit_value;
   logic              div_done;
   logic [DATA_W-1:0] div_quo;

   assign top_idx    = IW'(count_ff - CW'(1));
   assign second_idx = IW'(count_ff - CW'(2));

   // stack read address
   always_comb begin
      case (ctl.rd_sel)
         RD_TOP:    rd_addr = top_idx;
         RD_SECOND: rd_addr = second_idx;
         RD_NEXT:   rd_addr = ptr_ff - 1'b1;
         default:   rd_addr = top_idx;
      endcase
   end

   // stack write port: push or operator write-back
   assign wr_en   = ctl.push | ctl.pop_wb;
   assign wr_addr = ctl.push ? count_ff[IW-1:0] : second_idx;
   assign wr_data = ctl.push ? number_ff : result_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // add, subtract and the low half of the product
   always_comb begin
      case (operator_ff)
         OP_ADD:  alu_out = lhs_ff + rhs_ff;
         OP_SUB:  alu_out = lhs_ff - rhs_ff;
         OP_MUL:  alu_out = lhs_ff * rhs_ff;
         default: alu_out = lhs_ff + rhs_ff;
      endcase
   end

   rsc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (lhs_ff),
      .divisor  (rhs_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      result_in = result_ff;
      if (ctl.calc) begin
         result_in = alu_out;
      end else if (ctl.div_capture) begin
         result_in = div_quo;
      end
   end

   // entry count and dump cursor
   always_comb begin
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      remain_in = remain_ff;
      if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop_wb) begin
         count_in = count_ff - 1'b1;
      end else if (ctl.clear) begin
         count_in = '0;
      end
      if (ctl.dump_start) begin
         ptr_in = top_idx;
         if (32'(count_ff) > MAX_RESULTS) begin
            remain_in = CW'(MAX_RESULTS);
         end else begin
            remain_in = count_ff;
         end
      end else if (ctl.dump_step) begin
         ptr_in    = ptr_ff - 1'b1;
         remain_in = remain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      ptr_ff    <= ptr_in;
      remain_ff <= remain_in;
      result_ff <= result_in;
      if (ctl.load) begin
         cmd_ff      <= req_cmd;
         number_ff   <= req_number;
         operator_ff <= req_operator;
      end
      if (ctl.cap_rhs) begin
         rhs_ff <= rd_data_ff;
      end
      if (ctl.cap_lhs) begin
         lhs_ff <= rd_data_ff;
      end
   end

   // response output register
   always_comb begin
      case (ctl.emit_val)
         VAL_RESULT: emit_value = result_ff;
         VAL_RDATA:  emit_value = rd_data_ff;
         default:    emit_value = '0;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctl.emit) begin
         rsp_value_ff     <= emit_value;
         rsp_status_ff    <= ctl.emit_status;
         rsp_has_value_ff <= (ctl.emit_val != VAL_ZERO);
         rsp_last_ff      <= ctl.emit_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_has_value = rsp_has_value_ff;
   assign rsp_last      = rsp_last_ff;

   // status towards the controller
   always_comb begin
      sts.cmd          = cmd_ff;
      sts.operator_sel = operator_ff;
      sts.empty        = (count_ff == '0);
      sts.full         = (count_ff == CW'(STACK_DEPTH));
      sts.few          = (count_ff < CW'(2));
      sts.rhs_zero     = (rhs_ff == '0);
      sts.div_done     = div_done;
      sts.out_free     = !rsp_valid_ff || !rsp_stall;
      sts.dump_last    = (remain_ff == CW'(1));
   end

endmodule

[src/rsc_controller.sv]
module rsc_controller
   import rsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  rsc_sts_type sts,
   output rsc_ctl_type ctl
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_RD_LHS  = 4'd2;
   localparam logic [3:0] S_CAP     = 4'd3;
   localparam logic [3:0] S_CALC    = 4'd4;
   localparam logic [3:0] S_DIV     = 4'd5;
   localparam logic [3:0] S_WB      = 4'd6;
   localparam logic [3:0] S_PEEK    = 4'd7;
   localparam logic [3:0] S_DUMP    = 4'd8;
   localparam logic [3:0] S_ERR_DIV = 4'd9;

   logic [3:0] state_ff, state_in;

   // sequencing of one command
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.cmd)
               CMD_PUSH: begin
                  if (sts.out_free) begin
                     ctl.emit        = 1'b1;
                     ctl.emit_last   = 1'b1;
                     ctl.emit_val    = VAL_ZERO;
                     ctl.emit_status = sts.full ? ST_FULL : ST_OK;
                     ctl.push        = !sts.full;
                     state_in        = S_IDLE;
                  end
               end
               CMD_APPLY: begin
                  if (sts.few) begin
                     if (sts.out_free) begin
                        ctl.emit        = 1'b1;
                        ctl.emit_last   = 1'b1;
                        ctl.emit_val    = VAL_ZERO;
                        ctl.emit_status = ST_FEW;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     ctl.rd_en  = 1'b1;
                     ctl.rd_sel = RD_TOP;
                     state_in   = S_RD_LHS;
                  end
               end
               CMD_PEEK, CMD_DUMP: begin
                  if (sts.empty) begin
                     if (sts.out_free) begin
                        ctl.emit        = 1'b1;
                        ctl.emit_last   = 1'b1;
                        ctl.emit_val    = VAL_ZERO;
                        ctl.emit_status = ST_EMPTY;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     ctl.rd_en  = 1'b1;
                     ctl.rd_sel = RD_TOP;
                     if (sts.cmd == CMD_DUMP) begin
                        ctl.dump_start = 1'b1;
                        state_in       = S_DUMP;
                     end else begin
                        state_in = S_PEEK;
                     end
                  end
               end
               CMD_CLEAR: begin
                  if (sts.out_free) begin
                     ctl.emit        = 1'b1;
                     ctl.emit_last   = 1'b1;
                     ctl.emit_val    = VAL_ZERO;
                     ctl.emit_status = ST_OK;
                     ctl.clear       = 1'b1;
                     state_in        = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RD_LHS: begin
            ctl.cap_rhs = 1'b1;
            ctl.rd_en   = 1'b1;
            ctl.rd_sel  = RD_SECOND;
            state_in    = S_CAP;
         end
         S_CAP: begin
            ctl.cap_lhs = 1'b1;
            state_in    = S_CALC;
         end
         S_CALC: begin
            if (sts.operator_sel == OP_DIV) begin
               if (sts.rhs_zero) begin
                  state_in = S_ERR_DIV;
               end else begin
                  ctl.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end else begin
               ctl.calc = 1'b1;
               state_in = S_WB;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               ctl.div_capture = 1'b1;
               state_in        = S_WB;
            end
         end
         S_WB: begin
            if (sts.out_free) begin
               ctl.pop_wb      = 1'b1;
               ctl.emit        = 1'b1;
               ctl.emit_last   = 1'b1;
               ctl.emit_val    = VAL_RESULT;
               ctl.emit_status = ST_OK;
               state_in        = S_IDLE;
            end
         end
         S_PEEK: begin
            if (sts.out_free) begin
               ctl.emit        = 1'b1;
               ctl.emit_last   = 1'b1;
               ctl.emit_val    = VAL_RDATA;
               ctl.emit_status = ST_OK;
               state_in        = S_IDLE;
            end
         end
         S_DUMP: begin
            if (sts.out_free) begin
               ctl.emit        = 1'b1;
               ctl.emit_last   = sts.dump_last;
               ctl.emit_val    = VAL_RDATA;
               ctl.emit_status = ST_OK;
               if (sts.dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  ctl.dump_step = 1'b1;
                  ctl.rd_en     = 1'b1;
                  ctl.rd_sel    = RD_NEXT;
               end
            end
         end
         S_ERR_DIV: begin
            if (sts.out_free) begin
               ctl.emit        = 1'b1;
               ctl.emit_last   = 1'b1;
               ctl.emit_val    = VAL_ZERO;
               ctl.emit_status = ST_DIV0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

[verif/rsc_checker.sv]
`timescale 1ns / 1ps

// watches both channels, keeps its own copy of the operand stack and
// compares every response transaction with the oldest predicted one
module rsc_checker
   import rsc_pkg::*;
#(
   parameter int STACK_DEPTH = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic        [2:0]        req_cmd,
   input  logic signed [DATA_W-1:0] req_number,
   input  logic        [1:0]        req_operator,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [DATA_W-1:0] rsp_value,
   input  logic        [2:0]        rsp_status,
   input  logic                     rsp_has_value,
   input  logic                     rsp_last,
   output int unsigned              error_count,
   output int unsigned              pending_count
);

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic        [2:0]        status;
      logic                     has_value;
      logic                     last;
   } calc_reply_type;

   calc_reply_type           expected_replies[$];
   logic signed [DATA_W-1:0] operand_stack [STACK_DEPTH];
   int unsigned              stack_fill;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   // arithmetic on two operands, wrapping at the data width
   function automatic logic signed [DATA_W-1:0] apply_operator(
      input logic        [1:0]        op,
      input logic signed [DATA_W-1:0] lhs,
      input logic signed [DATA_W-1:0] rhs
   );
      longint quotient;
      case (op)
         OP_ADD: return lhs + rhs;
         OP_SUB: return lhs - rhs;
         OP_MUL: return lhs * rhs;
         default: begin
            // wide divide so that most negative over minus one wraps cleanly
            quotient = longint'(lhs) / longint'(rhs);
            return quotient[DATA_W-1:0];
         end
      endcase
   endfunction

   // update the stack copy and queue the replies one command causes
   task automatic predict_command(
      input logic        [2:0]        cmd,
      input logic signed [DATA_W-1:0] number,
      input logic        [1:0]        op
   );
      calc_reply_type           reply;
      logic signed [DATA_W-1:0] lhs;
      logic signed [DATA_W-1:0] rhs;
      int unsigned              idx;
      int                       emitted;
      reply      = '0;
      reply.last = 1'b1;
      case (cmd)
         CMD_PUSH: begin
            if (stack_fill >= STACK_DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               operand_stack[stack_fill] = number;
               stack_fill++;
            end
            expected_replies.push_back(reply);
         end
         CMD_APPLY: begin
            if (stack_fill < 2) begin
               reply.status = ST_FEW;
            end else begin
               lhs = operand_stack[stack_fill-2];
               rhs = operand_stack[stack_fill-1];
               if (op == OP_DIV && rhs == '0) begin
                  reply.status = ST_DIV0;
               end else begin
                  stack_fill--;
                  operand_stack[stack_fill-1] = apply_operator(op, lhs, rhs);
                  reply.value     = operand_stack[stack_fill-1];
                  reply.has_value = 1'b1;
               end
            end
            expected_replies.push_back(reply);
         end
         CMD_PEEK: begin
            if (stack_fill == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               reply.value     = operand_stack[stack_fill-1];
               reply.has_value = 1'b1;
            end
            expected_replies.push_back(reply);
         end
         CMD_DUMP: begin
            if (stack_fill == 0) begin
               reply.status = ST_EMPTY;
               expected_replies.push_back(reply);
            end else begin
               // top to bottom, capped at the most replies one command may give
               idx     = stack_fill;
               emitted = 0;
               while (idx > 0 && emitted < MAX_RESULTS) begin
                  idx--;
                  reply.value     = operand_stack[idx];
                  reply.has_value = 1'b1;
                  reply.last      = (idx == 0) || (emitted == MAX_RESULTS - 1);
                  expected_replies.push_back(reply);
                  emitted++;
               end
            end
         end
         CMD_CLEAR: begin
            stack_fill = 0;
            expected_replies.push_back(reply);
         end
         default: begin
            // reserved codes: no reply, no state change
         end
      endcase
   endtask

   // channel monitor, sampling on the rising edge
   always @(posedge clock) begin : watch_channels
      calc_reply_type want;
      if (reset) begin
         stack_fill = 0;
         expected_replies.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_command(req_cmd, req_number, req_operator);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction value %0d status %0d",
                                         rsp_value, rsp_status));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_value !== want.value)
                  report_mismatch($sformatf("value %0d, predicted %0d",
                                            rsp_value, want.value));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_status, want.status));
               if (rsp_has_value !== want.has_value)
                  report_mismatch($sformatf("has_value %0b, predicted %0b",
                                            rsp_has_value, want.has_value));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, predicted %0b",
                                            rsp_last, want.last));
            end
         end
      end
      pending_count <= expected_replies.size();
   end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import rsc_pkg::*;

   localparam int STACK_DEPTH  = 16;
   localparam int TOTAL_ITEMS  = 310;
   localparam int SETTLE_TIME  = 60;
   localparam int RUN_LIMIT_NS = 6_000_000;

   // command codes the block ignores
   localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

   localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

   logic                     clock         = 1'b0;
   logic                     reset         = 1'b1;
   logic                     req_valid     = 1'b0;
   logic                     req_stall;
   logic        [2:0]        req_cmd       = CMD_PUSH;
   logic signed [DATA_W-1:0] req_number    = '0;
   logic        [1:0]        req_operator  = OP_ADD;
   logic                     rsp_valid;
   logic                     rsp_stall     = 1'b0;
   logic signed [DATA_W-1:0] rsp_value;
   logic        [2:0]        rsp_status;
   logic                     rsp_has_value;
   logic                     rsp_last;
   int unsigned              error_count;
   int unsigned              pending_count;

   int unsigned stall_left  = 0;
   int unsigned burst_left  = 0;
   int unsigned items_sent  = 0;

   rpn_stack_calculator #(.STACK_DEPTH(STACK_DEPTH)) u_top (.*);

   rsc_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (.*);

   always #2 clock = ~clock;

   // hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("testbench: errors");
      $finish;
   end

   // receiver stall pattern: short bursts, free-running stretches, rare long holds
   always @(posedge clock) begin : stall_pattern
      int unsigned r;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 6);
         end else if (r < 85) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else if (r < 95) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(20, 80);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(20, 60);
         end
      end
   end

   // idle cycles after a request transaction
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // operand values biased towards zero, signs and the extremes
   function automatic logic signed [DATA_W-1:0] pick_number();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return '0;
      if (r < 22) return -1;
      if (r < 27) return 1;
      if (r < 32) return MOST_NEG;
      if (r < 37) return MOST_POS;
      if (r < 57) return $signed($urandom_range(0, 40)) - 20;
      return $urandom;
   endfunction

   // one request transaction; called just after a rising edge
   task automatic send_command(
      input logic        [2:0]        cmd,
      input logic signed [DATA_W-1:0] number,
      input logic        [1:0]        op
   );
      int unsigned gap;
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_number   <= number;
      req_operator <= op;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd <= CMD_CLEAR) items_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the sender until every predicted response has been seen
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // clear, overfill, read the full stack back, then apply once and peek
   task automatic fill_stack();
      send_command(CMD_CLEAR, pick_number(), OP_ADD);
      repeat (STACK_DEPTH + 2)
         send_command(CMD_PUSH, pick_number(), 2'($urandom_range(0, 3)));
      send_command(CMD_DUMP, pick_number(), 2'($urandom_range(0, 3)));
      send_command(CMD_APPLY, pick_number(), 2'($urandom_range(0, 3)));
      send_command(CMD_PEEK, pick_number(), 2'($urandom_range(0, 3)));
   endtask

   // push a few operands, fold some of them, then look at the result
   task automatic send_expression();
      int unsigned operands;
      operands = $urandom_range(2, 5);
      repeat (operands) send_command(CMD_PUSH, pick_number(), 2'($urandom_range(0, 3)));
      repeat ($urandom_range(1, operands))
         send_command(CMD_APPLY, pick_number(), 2'($urandom_range(0, 3)));
      if ($urandom_range(0, 1) == 0) send_command(CMD_PEEK, pick_number(), OP_ADD);
      else send_command(CMD_DUMP, pick_number(), OP_ADD);
   endtask

   initial begin : stimulus
      int unsigned pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty stack, too few operands, wrap, divide, reserved codes, clear
      send_command(CMD_PEEK,  '0, OP_ADD);
      send_command(CMD_DUMP,  '0, OP_ADD);
      send_command(CMD_APPLY, '0, OP_ADD);
      send_command(CMD_PUSH,  MOST_NEG, OP_ADD);
      send_command(CMD_APPLY, '0, OP_SUB);
      send_command(CMD_PUSH,  -1, OP_ADD);
      send_command(CMD_APPLY, '0, OP_DIV);
      send_command(CMD_PUSH,  '0, OP_ADD);
      send_command(CMD_APPLY, '0, OP_DIV);
      send_command(CMD_APPLY, '0, OP_MUL);
      send_command(CMD_PUSH,  MOST_POS, OP_ADD);
      send_command(CMD_APPLY, '0, OP_ADD);
      send_command(CMD_PUSH,  1, OP_ADD);
      send_command(CMD_APPLY, '0, OP_ADD);
      send_command(CMD_PUSH,  1, OP_ADD);
      send_command(CMD_APPLY, '0, OP_SUB);
      send_command(CMD_PUSH,  -7, OP_ADD);
      send_command(CMD_PUSH,  2, OP_ADD);
      send_command(CMD_APPLY, '0, OP_DIV);
      send_command(CMD_DUMP,  '0, OP_ADD);
      send_command(CMD_APPLY, '1, OP_MUL);
      for (int c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
         send_command(3'(c), '1, OP_DIV);
      send_command(CMD_CLEAR, '0, OP_ADD);
      send_command(CMD_PEEK,  '0, OP_ADD);
      wait_for_drain();

      // random: mostly well-formed expressions, some overfills and noise
      while (items_sent < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            fill_stack();
         end else if (pick < 70) begin
            send_expression();
         end else begin
            repeat ($urandom_range(1, 4))
               send_command(3'($urandom_range(0, 7)), pick_number(),
                            2'($urandom_range(0, 3)));
         end
         if ($urandom_range(0, 99) < 3) wait_for_drain();
      end

      wait_for_drain();
      repeat (SETTLE_TIME) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
